>>> design/ecev_pkg.sv
// Shared constants, types and codes for the ease curve evaluator.
package ecev_pkg;

	// Fixed-point format: Q2.16 progress in, Q1.16 weight out.
	localparam int FRAC_BITS    = 16;
	localparam int SINE_ENTRIES = 256;
	localparam int IDX_W        = $clog2(SINE_ENTRIES);
	localparam int ALPHA_W      = FRAC_BITS + 2;
	localparam int Q_W          = FRAC_BITS + 1;
	localparam int PROD_W       = 2 * Q_W;

	localparam logic [Q_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [Q_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

	// Half pi in Q30, the step base for the sine table.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [Q_W-1:0]    q_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Curve register codes.
	typedef enum logic [3:0] {
		CURVE_LINEAR      = 4'd0,
		CURVE_IN_SINE     = 4'd1,
		CURVE_OUT_SINE    = 4'd2,
		CURVE_INOUT_SINE  = 4'd3,
		CURVE_IN_QUAD     = 4'd4,
		CURVE_OUT_QUAD    = 4'd5,
		CURVE_INOUT_QUAD  = 4'd6,
		CURVE_IN_CUBIC    = 4'd7,
		CURVE_OUT_CUBIC   = 4'd8,
		CURVE_INOUT_CUBIC = 4'd9
	} curve_t;

	// Operation class that travels down the pipeline with each beat.
	typedef enum logic [2:0] {
		OP_LINEAR,
		OP_SINE,
		OP_SINE_SQ,
		OP_QUAD,
		OP_QUAD_DBL,
		OP_CUBIC
	} op_t;

	typedef struct packed {
		op_t  op;
		logic invert;
	} ctl_t;

	// Load enables for the inner pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

>>> design/ecev_sine_rom.sv
// Quarter-wave sine table, built at elaboration, read at two addresses.
module ecev_sine_rom
	import ecev_pkg::*;
(
	input  logic [IDX_W:0] lo_addr,
	input  logic [IDX_W:0] hi_addr,
	output q_t             lo_data,
	output q_t             hi_data
);

	// Entry k is sin(k*pi/(2*N)) from a Q30 Taylor series, rounded and capped at one.
	function automatic q_t sine_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + term;
		e    = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		if (e > 64'(ONE)) begin
			e = 64'(ONE);
		end
		return e[Q_W-1:0];
	endfunction

	q_t rom [0:SINE_ENTRIES];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		assign rom[k] = sine_entry(k);
	end

	assign lo_data = rom[lo_addr];
	assign hi_data = rom[hi_addr];

endmodule

>>> design/ecev_front.sv
// First stage: clamp, curve decode, operand selection and sine table lookup.
module ecev_front
	import ecev_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [ALPHA_W-1:0] alpha,
	input  logic [3:0]                curve,
	output ctl_t                      ctl_s1,
	output q_t                        ma_s1,
	output q_t                        mb_s1,
	output q_t                        lo_s1,
	output q_t                        x_s1
);

	localparam int POS_W = Q_W + IDX_W;

	q_t               a;
	q_t               b;
	q_t               x;
	q_t               y;
	logic             lower;
	logic             dbl;
	ctl_t             ctl;
	logic [POS_W-1:0] pos;
	logic [IDX_W:0]   lo_addr;
	logic [IDX_W:0]   hi_addr;
	q_t               lo;
	q_t               hi;
	q_t               d;
	q_t               f;
	logic             sine;

	// Clamp the progress to 0..one.
	always_comb begin
		if (alpha[ALPHA_W-1]) begin
			a = '0;
		end else if ($unsigned(alpha[ALPHA_W-2:0]) > ONE) begin
			a = ONE;
		end else begin
			a = alpha[Q_W-1:0];
		end
		b     = ONE - a;
		lower = (a < HALF);
	end

	// Decode the curve into an operand, a doubling flag and an operation class.
	always_comb begin
		x          = a;
		dbl        = 1'b0;
		ctl.op     = OP_LINEAR;
		ctl.invert = 1'b0;
		unique case (curve_t'(curve))
			CURVE_IN_SINE: begin
				x          = b;
				ctl.op     = OP_SINE;
				ctl.invert = 1'b1;
			end
			CURVE_OUT_SINE: begin
				ctl.op = OP_SINE;
			end
			CURVE_INOUT_SINE: begin
				ctl.op = OP_SINE_SQ;
			end
			CURVE_IN_QUAD: begin
				ctl.op = OP_QUAD;
			end
			CURVE_OUT_QUAD: begin
				x          = b;
				ctl.op     = OP_QUAD;
				ctl.invert = 1'b1;
			end
			CURVE_INOUT_QUAD: begin
				x          = lower ? a : b;
				ctl.op     = OP_QUAD_DBL;
				ctl.invert = !lower;
			end
			CURVE_IN_CUBIC: begin
				ctl.op = OP_CUBIC;
			end
			CURVE_OUT_CUBIC: begin
				x          = b;
				ctl.op     = OP_CUBIC;
				ctl.invert = 1'b1;
			end
			CURVE_INOUT_CUBIC: begin
				x          = lower ? a : b;
				dbl        = 1'b1;
				ctl.op     = OP_CUBIC;
				ctl.invert = !lower;
			end
			default: begin
				ctl.op = OP_LINEAR;
			end
		endcase
		y = dbl ? {x[Q_W-2:0], 1'b0} : x;
	end

	// Table position: the integer part picks two neighbours, the fraction weights them.
	always_comb begin
		pos     = POS_W'(x) * POS_W'(SINE_ENTRIES);
		lo_addr = pos[POS_W-1:FRAC_BITS];
		hi_addr = (lo_addr == (IDX_W + 1)'(SINE_ENTRIES)) ? lo_addr : lo_addr + 1'b1;
		f       = {1'b0, pos[FRAC_BITS-1:0]};
	end

	ecev_sine_rom u_rom (
		.lo_addr (lo_addr),
		.hi_addr (hi_addr),
		.lo_data (lo),
		.hi_data (hi)
	);

	// Sine curves multiply the step by the fraction; the rest square their operand.
	always_comb begin
		d    = (hi > lo) ? hi - lo : '0;
		sine = (ctl.op == OP_SINE) || (ctl.op == OP_SINE_SQ);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			ma_s1  <= sine ? d : y;
			mb_s1  <= sine ? f : y;
			lo_s1  <= lo;
			x_s1   <= x;
		end
	end

endmodule

>>> design/ecev_core.sv
// Stages two to four: first product, rounding, second product.
module ecev_core
	import ecev_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  ctl_t      ctl_s1,
	input  q_t        ma_s1,
	input  q_t        mb_s1,
	input  q_t        lo_s1,
	input  q_t        x_s1,
	output ctl_t      ctl_s4,
	output prod_t     m2_s4,
	output q_t        r1_s4
);

	ctl_t  ctl_s2;
	prod_t m1_s2;
	q_t    lo_s2;
	q_t    x_s2;
	ctl_t  ctl_s3;
	q_t    r1_s3;
	q_t    op2_s3;
	prod_t rnd;
	prod_t rnd_dbl;
	q_t    r1;
	q_t    op2;

	// Stage two: the first multiplication.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			ctl_s2 <= ctl_s1;
			m1_s2  <= PROD_W'(ma_s1) * PROD_W'(mb_s1);
			lo_s2  <= lo_s1;
			x_s2   <= x_s1;
		end
	end

	// Stage three: round the product to nearest and pick the second operand.
	always_comb begin
		rnd     = m1_s2 + PROD_W'(HALF);
		rnd_dbl = {m1_s2[PROD_W-2:0], 1'b0} + PROD_W'(HALF);
		unique case (ctl_s2.op)
			OP_SINE, OP_SINE_SQ: r1 = lo_s2 + rnd[FRAC_BITS +: Q_W];
			OP_QUAD, OP_CUBIC:   r1 = rnd[FRAC_BITS +: Q_W];
			OP_QUAD_DBL:         r1 = rnd_dbl[FRAC_BITS +: Q_W];
			default:             r1 = x_s2;
		endcase
		op2 = (ctl_s2.op == OP_SINE_SQ) ? r1 : x_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ctl_s3 <= ctl_s2;
			r1_s3  <= r1;
			op2_s3 <= op2;
		end
	end

	// Stage four: the second multiplication, for sine squared and cubes.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			ctl_s4 <= ctl_s3;
			m2_s4  <= PROD_W'(r1_s3) * PROD_W'(op2_s3);
			r1_s4  <= r1_s3;
		end
	end

endmodule

>>> design/ease_curve_evaluator_unit.sv
// Top level of the ease curve evaluator: handshake, curve register and final stage.
// An accepted alpha beat goes through stages one to five before its weight is valid.
// Throughput: one beat per cycle unless the output stalls; each of the five stages
// loads when it is empty or when the next stage moves, so bubbles fill during a stall.
// Stage one holds the sine table; each later stage, one multiplier or one rounding add.
// Reset clears the stage valid bits and sets the curve register to linear.
module ease_curve_evaluator_unit
	import ecev_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [3:0]                cfg_wdata,
	input  logic                      alpha_valid,
	output logic                      alpha_ready,
	input  logic signed [ALPHA_W-1:0] alpha,
	output logic                      weight_valid,
	input  logic                      weight_ready,
	output logic [Q_W-1:0]            weight
);

	logic [3:0] curve_q;
	stage_en_t  en;
	logic       en_s5;
	logic       v_s1;
	logic       v_s2;
	logic       v_s3;
	logic       v_s4;
	logic       v_s5;
	ctl_t       ctl_s1;
	q_t         ma_s1;
	q_t         mb_s1;
	q_t         lo_s1;
	q_t         x_s1;
	ctl_t       ctl_s4;
	prod_t      m2_s4;
	q_t         r1_s4;
	prod_t      rnd2;
	q_t         w;
	q_t         w_fin;
	q_t         weight_s5;

	// Curve register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= CURVE_LINEAR;
		end else if (cfg_we) begin
			curve_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		en_s5       = !v_s5 || weight_ready;
		en.s4       = !v_s4 || en_s5;
		en.s3       = !v_s3 || en.s4;
		en.s2       = !v_s2 || en.s3;
		en.s1       = !v_s1 || en.s2;
		alpha_ready = en.s1;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= alpha_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	ecev_front u_front (
		.clk    (clk),
		.en     (en.s1),
		.alpha  (alpha),
		.curve  (curve_q),
		.ctl_s1 (ctl_s1),
		.ma_s1  (ma_s1),
		.mb_s1  (mb_s1),
		.lo_s1  (lo_s1),
		.x_s1   (x_s1)
	);

	ecev_core u_core (
		.clk    (clk),
		.en     (en),
		.ctl_s1 (ctl_s1),
		.ma_s1  (ma_s1),
		.mb_s1  (mb_s1),
		.lo_s1  (lo_s1),
		.x_s1   (x_s1),
		.ctl_s4 (ctl_s4),
		.m2_s4  (m2_s4),
		.r1_s4  (r1_s4)
	);

	// Stage five: round the second product, mirror if needed and saturate.
	always_comb begin
		rnd2 = m2_s4 + PROD_W'(HALF);
		if ((ctl_s4.op == OP_SINE_SQ) || (ctl_s4.op == OP_CUBIC)) begin
			w = rnd2[FRAC_BITS +: Q_W];
		end else begin
			w = r1_s4;
		end
		if (w > ONE) begin
			w = ONE;
		end
		w_fin = ctl_s4.invert ? ONE - w : w;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			weight_s5 <= w_fin;
		end
	end

	assign weight_valid = v_s5;
	assign weight       = weight_s5;

`ifndef SYNTH
	// The weight never goes above one.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		weight_valid |-> (weight <= ONE))
		else $error("weight above one");

	// An empty output stage lets the whole pipeline move, so input is taken.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> alpha_ready)
		else $error("input refused with an empty output stage");

	// An accepted beat lands in stage one.
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(alpha_valid && alpha_ready) |=> v_s1)
		else $error("accepted beat lost at stage one");

	// A held stage keeps its beat.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en.s4) |=> v_s3)
		else $error("stalled beat dropped in stage three");
`endif

endmodule
